>>> hw/rtl/cfe_pkg.sv
`timescale 1ns / 1ps

package cfe_pkg;

    typedef enum logic [2:0] {
        CMD_COUNT = 3'd0,
        CMD_UINT  = 3'd1,
        CMD_SINT  = 3'd2,
        CMD_STR   = 3'd3,
        CMD_CHAR  = 3'd4
    } cmd_t;

    localparam logic [7:0] HDR_LAST    = 8'h80;
    localparam logic [7:0] HDR_STRING  = 8'h40;
    localparam logic [7:0] HDR_SIGNED  = 8'h20;
    localparam logic [7:0] STR_LEN_MSK = 8'h3f;
    localparam logic [7:0] INT_LEN_MSK = 8'h1f;
    localparam logic [31:0] SIGN_BIT   = 32'h8000_0000;

    typedef struct packed {
        cmd_t        cmd;
        logic        last_field;
        logic [31:0] value;
    } item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
    } result_t;

    typedef struct packed {
        logic [7:0]  first_byte;
        logic [31:0] data;
        logic [2:0]  n_data;
    } job_t;

endpackage

>>> hw/rtl/cfe_front.sv
`timescale 1ns / 1ps

module cfe_front
    import cfe_pkg::*;
(
    input  logic  item_valid,
    output logic  item_ready,
    input  item_t item,
    input  logic  full,
    output logic  push,
    output job_t  job
);

    logic [31:0] mag;
    logic [2:0]  n_uns;
    logic [2:0]  n_sgn;
    logic [7:0]  hdr_last;
    logic        known;

    assign item_ready = !full;

    always_comb
    begin
        if (item.value[31] == 1'b1)
        begin
            mag = ~item.value;
        end
        else
        begin
            mag = item.value;
        end
    end

    always_comb
    begin
        if (item.value[31:24] != 8'd0)
        begin
            n_uns = 3'd4;
        end
        else if (item.value[23:16] != 8'd0)
        begin
            n_uns = 3'd3;
        end
        else if (item.value[15:8] != 8'd0)
        begin
            n_uns = 3'd2;
        end
        else
        begin
            n_uns = 3'd1;
        end
    end

    always_comb
    begin
        if (mag[30:23] != 8'd0)
        begin
            n_sgn = 3'd4;
        end
        else if (mag[22:15] != 8'd0)
        begin
            n_sgn = 3'd3;
        end
        else if (mag[14:7] != 8'd0)
        begin
            n_sgn = 3'd2;
        end
        else
        begin
            n_sgn = 3'd1;
        end
    end

    assign hdr_last = item.last_field ? HDR_LAST : 8'h00;

    always_comb
    begin
        known          = 1'b1;
        job.first_byte = item.value[7:0];
        job.data       = item.value;
        job.n_data     = 3'd0;
        case (item.cmd)
            CMD_COUNT, CMD_CHAR:
            begin
                job.first_byte = item.value[7:0];
            end
            CMD_STR:
            begin
                job.first_byte = hdr_last | HDR_STRING | (item.value[7:0] & STR_LEN_MSK);
            end
            CMD_UINT:
            begin
                job.first_byte = hdr_last | ({5'd0, n_uns} & INT_LEN_MSK);
                job.n_data     = n_uns;
            end
            CMD_SINT:
            begin
                job.first_byte = hdr_last | HDR_SIGNED | ({5'd0, n_sgn} & INT_LEN_MSK);
                job.n_data     = n_sgn;
            end
            default:
            begin
                known = 1'b0;
            end
        endcase
    end

    // drop unused codes: accepted, no beat produced
    assign push = item_valid && !full && known;

endmodule

>>> hw/rtl/cfe_queue.sv
`timescale 1ns / 1ps

module cfe_queue
    import cfe_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output job_t head,
    output logic empty,
    output logic full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             push_en;
    logic             pop_en;

    assign empty   = (cnt_reg == CNT_W'(0));
    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign push_en = push && !full;
    assign pop_en  = pop && !empty;
    assign head    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? PTR_W'(0) : wr_ptr_reg + PTR_W'(1);
        end
        if (pop_en)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? PTR_W'(0) : rd_ptr_reg + PTR_W'(1);
        end
        if (push_en && !pop_en)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (pop_en && !push_en)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_en)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

>>> hw/rtl/cfe_back.sv
`timescale 1ns / 1ps

module cfe_back
    import cfe_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  job_t    head,
    input  logic    empty,
    output logic    pop,
    output logic    result_valid,
    input  logic    result_ready,
    output result_t result
);

    logic [31:0] data_reg;
    logic [31:0] data_next;
    logic [2:0]  rem_reg;
    logic [2:0]  rem_next;
    logic        outv_reg;
    logic        outv_next;
    result_t     out_reg;
    result_t     out_next;
    logic        load;
    logic        busy;
    logic [7:0]  sel_byte;

    assign load = !outv_reg || result_ready;
    assign busy = (rem_reg != 3'd0);
    assign pop  = load && !busy && !empty;

    always_comb
    begin
        case (rem_reg)
            3'd4:    sel_byte = data_reg[31:24];
            3'd3:    sel_byte = data_reg[23:16];
            3'd2:    sel_byte = data_reg[15:8];
            default: sel_byte = data_reg[7:0];
        endcase
    end

    always_comb
    begin
        data_next = data_reg;
        rem_next  = rem_reg;
        outv_next = outv_reg;
        out_next  = out_reg;
        if (load)
        begin
            if (busy)
            begin
                out_next.out_byte    = sel_byte;
                out_next.last_of_run = (rem_reg == 3'd1);
                rem_next             = rem_reg - 3'd1;
                outv_next            = 1'b1;
            end
            else if (!empty)
            begin
                out_next.out_byte    = head.first_byte;
                out_next.last_of_run = (head.n_data == 3'd0);
                rem_next             = head.n_data;
                data_next            = head.data;
                outv_next            = 1'b1;
            end
            else
            begin
                outv_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            outv_reg <= 1'b0;
        end
        else
        begin
            rem_reg  <= rem_next;
            outv_reg <= outv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        out_reg  <= out_next;
    end

    assign result_valid = outv_reg;
    assign result       = out_reg;

endmodule

>>> hw/rtl/compact_field_encoder.sv
`timescale 1ns / 1ps
// First beat of an item is registered in the job queue, then in the back-end output register.
// Throughput: one output beat per cycle while result_ready holds, set by the back-end serializer;
//   an integer item gives a header beat and 1 to 4 data beats, count, string and character items one beat,
//   unused codes are dropped at the front and produce no output beat.
// Input accepts every cycle while the job queue (QUEUE_DEPTH entries) has room.
// Reset clears queue pointers, serializer count and output valid; no flush needed.

module compact_field_encoder
    import cfe_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_ready,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_ready,
    output result_t result
);

    logic push;
    job_t push_job;
    job_t head;
    logic pop;
    logic empty;
    logic full;

    cfe_front u_front (
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .full       (full),
        .push       (push),
        .job        (push_job)
    );

    cfe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .empty    (empty),
        .full     (full)
    );

    cfe_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .empty        (empty),
        .pop          (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import cfe_pkg::*;

    localparam logic [2:0]  CMD_UNUSED_FIRST = 3'd5;
    localparam logic [2:0]  CMD_UNUSED_LAST  = 3'd7;
    localparam int unsigned MAX_WAIT         = 17;
    localparam int unsigned STALL_LIMIT      = 500;
    localparam int unsigned TAIL_CYCLES      = 8;
    localparam int unsigned RANDOM_ITEMS     = 500;

    class field_scoreboard;
        result_t     expected_beats[$];
        int unsigned errors;

        function void note_item(item_t it);
            logic [7:0]  hdr;
            logic [31:0] mag;
            int unsigned n;
            int unsigned k;
            hdr = it.last_field ? HDR_LAST : 8'h00;
            case (it.cmd)
                CMD_COUNT, CMD_CHAR:
                begin
                    expected_beats.push_back('{it.value[7:0], 1'b1});
                end
                CMD_STR:
                begin
                    expected_beats.push_back(
                        '{hdr | HDR_STRING | (it.value[7:0] & STR_LEN_MSK), 1'b1});
                end
                CMD_UINT, CMD_SINT:
                begin
                    n = 1;
                    if (it.cmd == CMD_SINT)
                    begin
                        mag = ((it.value & SIGN_BIT) != 0) ? ~it.value : it.value;
                        while (n < 4 && (mag >> (8 * n - 1)) != 0)
                            n++;
                        hdr = hdr | HDR_SIGNED;
                    end
                    else
                    begin
                        while (n < 4 && (it.value >> (8 * n)) != 0)
                            n++;
                    end
                    hdr = hdr | (8'(n) & INT_LEN_MSK);
                    expected_beats.push_back('{hdr, 1'b0});
                    for (k = 0; k < n; k++)
                        expected_beats.push_back(
                            '{8'(it.value >> (8 * (n - 1 - k))), (k + 1) == n});
                end
                default:
                begin
                end
            endcase
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_beat(result_t got);
            result_t want;
            if (expected_beats.size() == 0)
            begin
                report($sformatf("beat byte %02h last %0b with nothing expected",
                                 got.out_byte, got.last_of_run));
            end
            else
            begin
                want = expected_beats.pop_front();
                if (got.out_byte !== want.out_byte)
                    report($sformatf("out_byte %02h, expected %02h",
                                     got.out_byte, want.out_byte));
                if (got.last_of_run !== want.last_of_run)
                    report($sformatf("last_of_run %0b, expected %0b (byte %02h)",
                                     got.last_of_run, want.last_of_run, want.out_byte));
            end
        endtask
    endclass

    logic            clk          = 1'b0;
    logic            rst_n        = 1'b0;
    logic            item_valid   = 1'b0;
    logic            item_ready;
    item_t           item         = '0;
    logic            result_valid;
    logic            result_ready = 1'b0;
    result_t         result;
    field_scoreboard board        = new;
    int unsigned     calm_in      = 0;
    int unsigned     calm_out     = 0;
    int unsigned     encoded_items = 0;
    int unsigned     idle_cycles  = 0;

    compact_field_encoder dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int unsigned draw_wait(ref int unsigned calm);
        if (calm != 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 7) == 0)
        begin
            calm = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, MAX_WAIT);
    endfunction

    // enter and leave at a falling edge
    task automatic send_item(cmd_t cmd, logic last, logic [31:0] value);
        int unsigned gap;
        item_t beat;
        gap = draw_wait(calm_in);
        beat = '{cmd, last, value};
        if (gap != 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item <= beat;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (!item_ready);
        board.note_item(beat);
        if (cmd inside {CMD_COUNT, CMD_UINT, CMD_SINT, CMD_STR, CMD_CHAR})
            encoded_items++;
        @(negedge clk);
    endtask

    initial
    begin
        int unsigned gap;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            gap = draw_wait(calm_out);
            if (gap != 0)
            begin
                result_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            result_ready <= 1'b1;
            do
                @(posedge clk);
            while (!result_valid);
            board.check_beat(result);
            @(negedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && item_ready) || (result_valid && result_ready))
            idle_cycles <= 0;
        else if (idle_cycles == STALL_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        int unsigned code;
        int unsigned nfields;
        int unsigned f;
        int unsigned nb;
        int unsigned len;
        int unsigned nchars;
        logic [31:0] v;
        logic        last;

        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_item(CMD_COUNT, 1'b1, 32'hffff_ffff);
        send_item(CMD_COUNT, 1'b0, 32'h0000_0000);
        send_item(CMD_UINT,  1'b0, 32'h0000_0000);
        send_item(CMD_UINT,  1'b1, 32'h0000_00ff);
        send_item(CMD_UINT,  1'b0, 32'h0000_0100);
        send_item(CMD_UINT,  1'b0, 32'h0000_ffff);
        send_item(CMD_UINT,  1'b1, 32'h0001_0000);
        send_item(CMD_UINT,  1'b0, 32'h00ff_ffff);
        send_item(CMD_UINT,  1'b0, 32'h0100_0000);
        send_item(CMD_UINT,  1'b1, 32'hffff_ffff);
        send_item(CMD_SINT,  1'b0, 32'h0000_0000);
        send_item(CMD_SINT,  1'b1, 32'hffff_ffff);
        send_item(CMD_SINT,  1'b0, 32'h0000_0080);
        send_item(CMD_SINT,  1'b0, 32'hffff_ff7f);
        send_item(CMD_SINT,  1'b1, 32'h0000_8000);
        send_item(CMD_SINT,  1'b0, 32'hff7f_ffff);
        send_item(CMD_SINT,  1'b0, 32'h7fff_ffff);
        send_item(CMD_SINT,  1'b1, 32'h8000_0000);
        send_item(CMD_STR,   1'b1, 32'h0000_0000);
        send_item(CMD_STR,   1'b0, 32'hffff_ffff);
        send_item(CMD_CHAR,  1'b1, 32'habcd_ef41);
        for (code = CMD_UNUSED_FIRST; code <= CMD_UNUSED_LAST; code++)
            send_item(cmd_t'(3'(code)), 1'b1, $urandom);

        encoded_items = 0;
        while (encoded_items < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 19) == 0)
            begin
                // noise: any code, any payload
                send_item(cmd_t'(3'($urandom_range(0, CMD_UNUSED_LAST))),
                          1'($urandom_range(0, 1)), $urandom);
            end
            else
            begin
                if ($urandom_range(0, 3) == 0)
                    send_item(CMD_COUNT, 1'($urandom_range(0, 1)), $urandom);
                nfields = $urandom_range(1, 6);
                for (f = 0; f < nfields; f++)
                begin
                    last = (f == nfields - 1);
                    if ($urandom_range(0, 2) != 0)
                    begin
                        nb = $urandom_range(1, 4);
                        v = $urandom;
                        if ($urandom_range(0, 1) != 0)
                            send_item(CMD_UINT, last, v >> (8 * (4 - nb)));
                        else
                            send_item(CMD_SINT, last, $signed(v) >>> (8 * (4 - nb)));
                    end
                    else
                    begin
                        len = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 10);
                        send_item(CMD_STR, last, len);
                        nchars = len & STR_LEN_MSK;
                        if (nchars > 10)
                            nchars = 10;
                        repeat (nchars)
                            send_item(CMD_CHAR, 1'($urandom_range(0, 1)),
                                      ($urandom_range(0, 3) == 0) ? $urandom
                                                                  : $urandom_range(32, 126));
                    end
                end
            end
        end
        item_valid <= 1'b0;

        while (board.expected_beats.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (board.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
